// ----- rtl/core/fr_pkg.sv -----
package fr_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [WORD_BITS-1:0] MAX_MAG = {1'b0, {(WORD_BITS-1){1'b1}}};

	typedef enum logic [1:0] {
		CLS_NORMAL,
		CLS_ZERO,
		CLS_INVALID
	} fr_cls_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] num_in;
		logic signed [WORD_BITS-1:0] den_in;
	} fr_in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] num_out;
		logic [WORD_BITS-2:0]        den_out;
		logic                        reduced;
		logic                        invalid;
	} fr_out_t;

	// classified transaction handed from front to back
	typedef struct packed {
		fr_cls_t              cls;
		logic [WORD_BITS-1:0] raw_num;
		logic [WORD_BITS-1:0] nmag;
		logic [WORD_BITS-1:0] dmag;
		logic                 neg;
	} fr_entry_t;

	// magnitude of a two's complement word; the most negative value maps to 2^(W-1)
	function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] m;
		m = v[WORD_BITS-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

endpackage

// ----- rtl/core/fr_front.sv -----
module fr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fr_pkg::fr_in_t    req,
	output logic              q_valid,
	input  logic              q_ready,
	output fr_pkg::fr_entry_t q_entry
);
	import fr_pkg::*;

	fr_entry_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wp_q;
	logic [QPTR_W-1:0]   rp_q;
	logic [QCNT_W-1:0]   cnt_q;
	fr_entry_t           ent;
	logic                push;
	logic                pop;

	always_comb begin
		ent.raw_num = req.num_in;
		ent.nmag    = mag_of(req.num_in);
		ent.dmag    = mag_of(req.den_in);
		ent.neg     = req.num_in[WORD_BITS-1] ^ req.den_in[WORD_BITS-1];
		if (req.den_in == '0) begin
			ent.cls = CLS_INVALID;
		end else if (req.num_in == '0) begin
			ent.cls = CLS_ZERO;
		end else begin
			ent.cls = CLS_NORMAL;
		end
	end

	assign req_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign q_valid   = (cnt_q != '0);
	assign q_entry   = mem_q[rp_q];
	assign push      = req_valid && req_ready;
	assign pop       = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QPTR_W'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QPTR_W'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/fr_back.sv -----
module fr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  fr_pkg::fr_entry_t q_entry,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output fr_pkg::fr_out_t   rsp
);
	import fr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t               state_q;
	fr_entry_t            ent_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [CNT_W-1:0]     k_q;
	logic [WORD_BITS-1:0] g_q;
	logic                 red_q;
	logic [WORD_BITS:0]   rn_q;
	logic [WORD_BITS:0]   rd_q;
	logic [WORD_BITS-1:0] nq_q;
	logic [WORD_BITS-1:0] dq_q;
	logic [CNT_W-1:0]     cnt_q;
	fr_out_t              rsp_q;
	logic                 rsp_valid_q;

	logic [WORD_BITS:0]   diff;
	logic [WORD_BITS-1:0] g_nxt;
	logic [WORD_BITS:0]   rn_try;
	logic [WORD_BITS:0]   rd_try;
	logic [WORD_BITS:0]   dvs;
	logic                 nbit;
	logic                 dbit;
	logic [WORD_BITS-1:0] nres;
	logic [WORD_BITS-1:0] dres;
	fr_out_t              fin;
	logic                 out_free;

	assign q_ready   = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		diff   = {1'b0, a_q} - {1'b0, b_q};
		g_nxt  = a_q << k_q;
		dvs    = {1'b0, g_q};
		rn_try = {rn_q[WORD_BITS-1:0], nq_q[WORD_BITS-1]};
		rd_try = {rd_q[WORD_BITS-1:0], dq_q[WORD_BITS-1]};
		nbit   = (rn_try >= dvs);
		dbit   = (rd_try >= dvs);
	end

	always_comb begin
		case (ent_q.cls)
			CLS_NORMAL: begin
				nres = nq_q;
				dres = dq_q;
			end
			default: begin
				nres = '0;
				dres = ent_q.dmag;
			end
		endcase
		if (nres > MAX_MAG) nres = MAX_MAG;
		if (dres > MAX_MAG) dres = MAX_MAG;
		if (ent_q.cls == CLS_INVALID) begin
			fin.num_out = ent_q.raw_num;
			fin.den_out = '0;
			fin.reduced = 1'b0;
			fin.invalid = 1'b1;
		end else begin
			fin.num_out = ent_q.neg ? (~nres + 1'b1) : nres;
			fin.den_out = dres[WORD_BITS-2:0];
			fin.reduced = (ent_q.cls == CLS_NORMAL) && red_q;
			fin.invalid = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					ent_q <= q_entry;
					a_q   <= q_entry.nmag;
					b_q   <= q_entry.dmag;
					k_q   <= '0;
				end
			end
			ST_GCD: begin
				if (a_q == b_q) begin
					g_q   <= g_nxt;
					red_q <= (g_nxt != WORD_BITS'(1));
					rn_q  <= '0;
					rd_q  <= '0;
					nq_q  <= ent_q.nmag;
					dq_q  <= ent_q.dmag;
					cnt_q <= CNT_W'(WORD_BITS - 1);
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (!diff[WORD_BITS]) begin
					a_q <= diff[WORD_BITS-1:0] >> 1;
				end else begin
					b_q <= (~diff[WORD_BITS-1:0] + 1'b1) >> 1;
				end
			end
			ST_DIV: begin
				rn_q  <= nbit ? (rn_try - dvs) : rn_try;
				rd_q  <= dbit ? (rd_try - dvs) : rd_try;
				nq_q  <= {nq_q[WORD_BITS-2:0], nbit};
				dq_q  <= {dq_q[WORD_BITS-2:0], dbit};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= (q_entry.cls == CLS_NORMAL) ? ST_GCD : ST_FIN;
					end
				end
				ST_GCD: begin
					if (a_q == b_q) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIN && out_free) begin
				rsp_q       <= fin;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/fraction_reducer.sv -----
// Zero denominator or zero numerator: the back end skips straight to the
// result. Otherwise a binary GCD loop runs, then a shift-subtract division of
// both magnitudes by the GCD in parallel.
// Throughput: one transaction per back-end pass; the back end takes no new
// entry until the last result is registered. A 2-entry queue decouples input.
// Reset (arst_n, async, active low) empties the queue and the result register.
module fraction_reducer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  fr_pkg::fr_in_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output fr_pkg::fr_out_t rsp
);
	import fr_pkg::*;

	logic      q_valid;
	logic      q_ready;
	fr_entry_t q_entry;

	fr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry)
	);

	fr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.invalid |-> rsp.den_out == '0 && !rsp.reduced)
		else $error("invalid transaction carries denominator or reduced flag");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.invalid |-> rsp.den_out != '0)
		else $error("valid transaction has zero denominator");

	a_reduced_num: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reduced |-> rsp.num_out != '0)
		else $error("reduced transaction has zero numerator");

endmodule
